>>> hw/rtl/bba_pkg.sv
// Shared constants, types and helpers for the label bounding-box accumulator.
`default_nettype none
package bba_pkg;

	localparam int NUM_LABELS  = 64;
	localparam int MAX_DIM     = 1024;
	localparam int MAX_RESULTS = 63;

	// Fixed field widths of the stream payloads
	localparam int LABEL_W  = 6;
	localparam int POS_W    = 10;
	localparam int EXT_W    = 11;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 48;

	// Internal widths that follow the table and image sizes
	localparam int IDX_W   = $clog2(NUM_LABELS);
	localparam int COORD_W = $clog2(MAX_DIM);
	localparam int ENTRY_W = 4 * COORD_W;
	localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

	// Queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic               flush;
		logic [IDX_W-1:0]   idx;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} qitem_t;

	// Table entry as held in the RAM
	typedef struct packed {
		logic [COORD_W-1:0] cmax;
		logic [COORD_W-1:0] cmin;
		logic [COORD_W-1:0] rmax;
		logic [COORD_W-1:0] rmin;
	} entry_t;

	// Result payload, lowest field in the lowest bits
	typedef struct packed {
		logic [EXT_W-1:0]   col_extent;
		logic [EXT_W-1:0]   row_extent;
		logic [POS_W-1:0]   col_start;
		logic [POS_W-1:0]   row_start;
		logic [LABEL_W-1:0] box_label;
	} box_t;

	function automatic logic [COORD_W-1:0] clamp_dim(input logic [POS_W-1:0] v);
		logic [COORD_W-1:0] res;
		if (32'(v) >= MAX_DIM) begin
			res = COORD_W'(MAX_DIM - 1);
		end else begin
			res = COORD_W'(v);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/bba_front.sv
// Input side: classifies incoming items and queues the ones that need work.
`default_nettype none
module bba_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [bba_pkg::S_DATA_W-1:0] s_tdata,  // label, row, col, zero pad
	input  wire logic                         s_tuser,  // mode: 1 = flush
	output logic                              q_valid,
	output bba_pkg::qitem_t                   q_item,
	input  wire logic                         pop
);

	logic [bba_pkg::LABEL_W-1:0] label;
	logic [bba_pkg::POS_W-1:0]   row;
	logic [bba_pkg::POS_W-1:0]   col;
	logic                        keep;
	logic                        push;
	bba_pkg::qitem_t             item;

	bba_pkg::qitem_t                 queue_q [bba_pkg::QUEUE_DEPTH];
	logic [bba_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bba_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bba_pkg::QCNT_W-1:0]      count_q;

	assign label = s_tdata[bba_pkg::LABEL_W-1:0];
	assign row   = s_tdata[bba_pkg::LABEL_W +: bba_pkg::POS_W];
	assign col   = s_tdata[bba_pkg::LABEL_W + bba_pkg::POS_W +: bba_pkg::POS_W];

	// background and out-of-table labels are taken and dropped here
	assign keep = s_tuser || (label != '0 && 32'(label) < bba_pkg::NUM_LABELS);

	assign s_tready = (count_q != bba_pkg::QCNT_W'(bba_pkg::QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready && keep;

	always_comb begin
		item.flush = s_tuser;
		item.idx   = bba_pkg::IDX_W'(label);
		item.row   = bba_pkg::clamp_dim(row);
		item.col   = bba_pkg::clamp_dim(col);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bba_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= bba_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= bba_pkg::QCNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= bba_pkg::QCNT_W'(count_q - 1'b1);
			end
		end
	end

	assign q_valid = (count_q != '0);
	assign q_item  = queue_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> hw/rtl/bba_back.sv
// Work side: table read-modify-write for pixels, scan and emit for flushes.
`default_nettype none
module bba_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire bba_pkg::qitem_t              q_item,
	output logic                              pop,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [bba_pkg::M_DATA_W-1:0]      m_tdata,  // box_label, row_start, col_start,
	                                                    // row_extent, col_extent
	output logic                              m_tuser,  // box_valid
	output logic                              m_tlast
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_BOX  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	localparam logic [bba_pkg::IDX_W-1:0] LAST_IDX = bba_pkg::IDX_W'(bba_pkg::NUM_LABELS - 1);
	localparam logic [bba_pkg::IDX_W-1:0] FIRST_IDX = bba_pkg::IDX_W'(1);

	state_t                          state_q;
	logic [bba_pkg::NUM_LABELS-1:0]  seen_q;
	logic [bba_pkg::IDX_W-1:0]       k_q;
	logic [bba_pkg::CNT_W-1:0]       cnt_q;
	logic [bba_pkg::IDX_W-1:0]       pix_idx_q;
	logic [bba_pkg::COORD_W-1:0]     pix_row_q;
	logic [bba_pkg::COORD_W-1:0]     pix_col_q;
	logic                            hold_vld_q;
	bba_pkg::box_t                   hold_q;
	logic                            m_tvalid_q;
	logic                            m_tuser_q;
	logic                            m_tlast_q;
	bba_pkg::box_t                   m_box_q;

	logic                            rd_en;
	logic [bba_pkg::IDX_W-1:0]       rd_addr;
	logic                            wr_en;
	bba_pkg::entry_t                 rd_entry;
	bba_pkg::entry_t                 new_entry;
	bba_pkg::box_t                   cur_box;
	logic                            can_emit;
	logic                            box_go;
	logic                            done_go;
	logic                            emit;
	logic                            emit_vld;
	logic                            emit_last;
	bba_pkg::box_t                   emit_box;

	bba_ram #(
		.WIDTH(bba_pkg::ENTRY_W),
		.DEPTH(bba_pkg::NUM_LABELS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(pix_idx_q),
		.wr_data(new_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_entry)
	);

	assign can_emit = !m_tvalid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && q_valid;

	// read port: pixel lookup from the queue head, or the scan position
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q;
		if (state_q == ST_IDLE) begin
			rd_en   = q_valid && !q_item.flush;
			rd_addr = q_item.idx;
		end else if (state_q == ST_SCAN) begin
			rd_en = seen_q[k_q];
		end
	end

	// min/max update; a first hit initialises the entry
	always_comb begin
		wr_en = (state_q == ST_UPD);
		if (!seen_q[pix_idx_q]) begin
			new_entry.rmin = pix_row_q;
			new_entry.rmax = pix_row_q;
			new_entry.cmin = pix_col_q;
			new_entry.cmax = pix_col_q;
		end else begin
			new_entry.rmin = (pix_row_q < rd_entry.rmin) ? pix_row_q : rd_entry.rmin;
			new_entry.rmax = (pix_row_q > rd_entry.rmax) ? pix_row_q : rd_entry.rmax;
			new_entry.cmin = (pix_col_q < rd_entry.cmin) ? pix_col_q : rd_entry.cmin;
			new_entry.cmax = (pix_col_q > rd_entry.cmax) ? pix_col_q : rd_entry.cmax;
		end
	end

	always_comb begin
		cur_box.box_label  = bba_pkg::LABEL_W'(k_q);
		cur_box.row_start  = bba_pkg::POS_W'(rd_entry.rmin);
		cur_box.col_start  = bba_pkg::POS_W'(rd_entry.cmin);
		cur_box.row_extent = bba_pkg::EXT_W'({1'b0, rd_entry.rmax} - {1'b0, rd_entry.rmin}
			+ 1'b1);
		cur_box.col_extent = bba_pkg::EXT_W'({1'b0, rd_entry.cmax} - {1'b0, rd_entry.cmin}
			+ 1'b1);
	end

	// one box is held back so the final one can carry tlast
	assign box_go  = (state_q == ST_BOX) && (!hold_vld_q || can_emit);
	assign done_go = (state_q == ST_DONE) && can_emit;

	always_comb begin
		emit      = 1'b0;
		emit_vld  = hold_vld_q;
		emit_last = 1'b0;
		emit_box  = hold_q;
		if (box_go && hold_vld_q) begin
			emit = 1'b1;
		end else if (done_go) begin
			emit      = 1'b1;
			emit_last = 1'b1;
			if (!hold_vld_q) begin
				emit_box = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pix_idx_q <= q_item.idx;
			pix_row_q <= q_item.row;
			pix_col_q <= q_item.col;
		end
		if (box_go) begin
			hold_q <= cur_box;
		end
		if (emit) begin
			m_box_q   <= emit_box;
			m_tuser_q <= emit_vld;
			m_tlast_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seen_q     <= '0;
			k_q        <= FIRST_IDX;
			cnt_q      <= '0;
			hold_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= q_item.flush ? ST_SCAN : ST_UPD;
					end
				end
				ST_UPD: begin
					seen_q[pix_idx_q] <= 1'b1;
					state_q           <= ST_IDLE;
				end
				ST_SCAN: begin
					if (seen_q[k_q]) begin
						state_q <= ST_BOX;
					end else if (k_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= bba_pkg::IDX_W'(k_q + 1'b1);
					end
				end
				ST_BOX: begin
					if (box_go) begin
						hold_vld_q <= 1'b1;
						cnt_q      <= bba_pkg::CNT_W'(cnt_q + 1'b1);
						if (cnt_q == bba_pkg::CNT_W'(bba_pkg::MAX_RESULTS - 1)
							|| k_q == LAST_IDX) begin
							state_q <= ST_DONE;
						end else begin
							k_q     <= bba_pkg::IDX_W'(k_q + 1'b1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_DONE: begin
					if (done_go) begin
						seen_q     <= '0;
						hold_vld_q <= 1'b0;
						cnt_q      <= '0;
						k_q        <= FIRST_IDX;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_box_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

>>> hw/rtl/label_bounding_box_accumulator_core.sv
// Label bounding-box accumulator: top level joining the front queue and the back sequencer.
// Input stream: one transfer per item. tuser = 1 is a flush, tuser = 0 a labelled
// pixel in tdata (label, row, col). Label 0 is background; pixels give no output.
// Output stream: on a flush, one transfer per seen label in ascending label order,
// tdata = label, row start, column start, row extent, column extent; tuser = 1
// marks a real box, tlast marks the final transfer. A frame with no labelled
// pixel yields a single transfer with tuser = 0, tlast = 1 and zero data.
// Buffering: a two-entry queue sits between the input and the table logic, so the
// input can keep taking items while the table logic works or the output is stalled,
// until the queue is full. A pixel passes through the table logic as a RAM read,
// then min/max and write back through the single write port. A flush is popped,
// then scans the labels upwards, spends an extra box step on each seen label and
// ends with a closing step. Each box is held back until the scan reaches the next
// seen label or ends, so that tlast can be set. Background pixels skip the table logic.
// The table is cleared at the end of each flush by resetting per-label seen flags.
// Reset (arst_n low) empties the queue, clears all seen flags and the output valid.
// A stalled receiver holds the output register; the scan waits on it, and the
// queue, then the input tready, back up behind it.
`default_nettype none
module label_bounding_box_accumulator_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [bba_pkg::S_DATA_W-1:0] s_tdata,  // label, row, col, zero pad
	input  wire logic                         s_tuser,  // mode: 1 = flush
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [bba_pkg::M_DATA_W-1:0]      m_tdata,  // box_label, row_start, col_start,
	                                                    // row_extent, col_extent
	output logic                              m_tuser,  // box_valid
	output logic                              m_tlast
);

	logic            q_valid;
	bba_pkg::qitem_t q_item;
	logic            pop;

	bba_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop)
	);

	bba_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

`ifndef SYNTHESIS
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue popped while empty");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("input stalled with an empty queue");

	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
		else $error("empty-frame result malformed");
`endif

endmodule
`default_nettype wire

>>> test/bbox_checker.sv
// Pixel mode codes and the checker that predicts and compares bounding-box results.
`timescale 1ns / 1ps

package bbox_tb_pkg;
	typedef enum logic {
		MODE_PIXEL = 1'b0,
		MODE_FLUSH = 1'b1
	} pixel_mode_e;
endpackage

module bbox_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	input  wire logic                         s_tready,
	input  wire logic [bba_pkg::S_DATA_W-1:0] s_tdata,
	input  wire logic                         s_tuser,
	input  wire logic                         m_tvalid,
	input  wire logic                         m_tready,
	input  wire logic [bba_pkg::M_DATA_W-1:0] m_tdata,
	input  wire logic                         m_tuser,
	input  wire logic                         m_tlast,
	output logic [31:0]                       mismatches,
	output logic [31:0]                       boxes_pending
);
	import bba_pkg::*;
	import bbox_tb_pkg::*;

	typedef struct packed {
		logic               box_valid;
		logic [LABEL_W-1:0] box_label;
		logic [POS_W-1:0]   row_start;
		logic [POS_W-1:0]   col_start;
		logic [EXT_W-1:0]   row_extent;
		logic [EXT_W-1:0]   col_extent;
		logic               last;
	} box_result_t;

	// running box per label, as the frame so far has built it
	bit               seen [NUM_LABELS];
	logic [POS_W-1:0] row_lo [NUM_LABELS];
	logic [POS_W-1:0] row_hi [NUM_LABELS];
	logic [POS_W-1:0] col_lo [NUM_LABELS];
	logic [POS_W-1:0] col_hi [NUM_LABELS];

	box_result_t boxes_due [$];
	int unsigned fails = 0;

	function automatic void record_pixel(input logic [LABEL_W-1:0] lab,
	                                     input logic [POS_W-1:0] r_in, c_in);
		logic [POS_W-1:0] r;
		logic [POS_W-1:0] c;
		r = (int'(r_in) >= MAX_DIM) ? POS_W'(MAX_DIM - 1) : r_in;
		c = (int'(c_in) >= MAX_DIM) ? POS_W'(MAX_DIM - 1) : c_in;
		// background, or a label the table has no room for
		if (lab == 0 || int'(lab) >= NUM_LABELS)
			return;
		if (!seen[lab]) begin
			seen[lab]   = 1'b1;
			row_lo[lab] = r;
			row_hi[lab] = r;
			col_lo[lab] = c;
			col_hi[lab] = c;
		end else begin
			if (r < row_lo[lab]) row_lo[lab] = r;
			if (r > row_hi[lab]) row_hi[lab] = r;
			if (c < col_lo[lab]) col_lo[lab] = c;
			if (c > col_hi[lab]) col_hi[lab] = c;
		end
	endfunction

	// walk labels upwards, queue one box per seen label, then clear the frame
	function automatic void emit_boxes();
		box_result_t b;
		int          total;
		int          n;
		total = 0;
		n     = 0;
		for (int k = 1; k < NUM_LABELS; k++)
			if (seen[k] && total < MAX_RESULTS) total++;
		for (int k = 1; k < NUM_LABELS && n < total; k++) begin
			if (seen[k]) begin
				n            = n + 1;
				b.box_valid  = 1'b1;
				b.box_label  = LABEL_W'(k);
				b.row_start  = row_lo[k];
				b.col_start  = col_lo[k];
				b.row_extent = EXT_W'(row_hi[k]) - EXT_W'(row_lo[k]) + EXT_W'(1);
				b.col_extent = EXT_W'(col_hi[k]) - EXT_W'(col_lo[k]) + EXT_W'(1);
				b.last       = (n == total);
				boxes_due.push_back(b);
			end
		end
		if (total == 0) begin
			b      = '0;
			b.last = 1'b1;
			boxes_due.push_back(b);
		end
		for (int k = 0; k < NUM_LABELS; k++)
			seen[k] = 1'b0;
	endfunction

	function automatic void check_field(input string what, input int unsigned want, got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		box_t        bx;
		box_result_t got;
		box_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == MODE_FLUSH)
					emit_boxes();
				else
					record_pixel(s_tdata[5:0], s_tdata[15:6], s_tdata[25:16]);
			end
			if (m_tvalid && m_tready) begin
				bx  = m_tdata;
				got = '{m_tuser, bx.box_label, bx.row_start, bx.col_start,
				        bx.row_extent, bx.col_extent, m_tlast};
				if (boxes_due.size() == 0) begin
					$display("%0t: box transfer expected none, got valid %0d label %0d last %0d",
					         $time, got.box_valid, got.box_label, got.last);
					fails++;
				end else begin
					want = boxes_due.pop_front();
					check_field("box_valid", want.box_valid, got.box_valid);
					check_field("box_label", want.box_label, got.box_label);
					check_field("row_start", want.row_start, got.row_start);
					check_field("col_start", want.col_start, got.col_start);
					check_field("row_extent", want.row_extent, got.row_extent);
					check_field("col_extent", want.col_extent, got.col_extent);
					check_field("last", want.last, got.last);
				end
			end
		end
		mismatches    <= fails;
		boxes_pending <= boxes_due.size();
	end

endmodule

>>> test/testbench.sv
// Top of the bounding-box accumulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import bba_pkg::*;
	import bbox_tb_pkg::*;

	localparam int ITEMS         = 470;
	localparam int STALL_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 160;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                s_tuser  = 1'b0;
	logic                m_tready = 1'b0;
	wire                 s_tready;
	wire                 m_tvalid;
	wire  [M_DATA_W-1:0] m_tdata;
	wire                 m_tuser;
	wire                 m_tlast;
	wire  [31:0]         mismatches;
	wire  [31:0]         boxes_pending;

	int items_sent  = 0;
	int idle_cycles = 0;
	bit calm        = 1'b0;

	always #5 clk = ~clk;

	label_bounding_box_accumulator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	bbox_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.boxes_pending (boxes_pending)
	);

	// coordinates lean on the image edges now and then
	function automatic logic [POS_W-1:0] pick_pos();
		logic [POS_W-1:0] p;
		case ($urandom_range(0, 7))
			0:       p = '0;
			1:       p = '1;
			default: p = POS_W'($urandom);
		endcase
		return p;
	endfunction

	task automatic send_item(input pixel_mode_e mode, input logic [LABEL_W-1:0] lab,
	                         input logic [POS_W-1:0] r, c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'b0, c, r, lab};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// label, row and col of a flush carry junk on purpose
	task automatic flush_frame();
		send_item(MODE_FLUSH, LABEL_W'($urandom), POS_W'($urandom), POS_W'($urandom));
	endtask

	// receiver: random stall before each result, none while calm
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int               n;
		int               kind;
		int               sweeps;
		logic [LABEL_W-1:0] base;
		logic [LABEL_W-1:0] lab;
		sweeps = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty frames: nothing at all, then background only
		flush_frame();
		send_item(MODE_PIXEL, 6'd0, 10'd1023, 10'd1023);
		flush_frame();
		// full-image boxes on the outermost labels
		send_item(MODE_PIXEL, 6'd1, 10'd0, 10'd0);
		send_item(MODE_PIXEL, 6'd63, 10'd1023, 10'd1023);
		send_item(MODE_PIXEL, 6'd1, 10'd1023, 10'd1023);
		send_item(MODE_PIXEL, 6'd0, 10'd512, 10'd512);
		send_item(MODE_PIXEL, 6'd63, 10'd0, 10'd0);
		// single-pixel boxes with alternating bit patterns
		send_item(MODE_PIXEL, 6'd42, 10'd682, 10'd341);
		send_item(MODE_PIXEL, 6'd21, 10'd341, 10'd682);
		// minimum drops below the first pixel
		send_item(MODE_PIXEL, 6'd32, 10'd600, 10'd9);
		send_item(MODE_PIXEL, 6'd32, 10'd400, 10'd900);
		send_item(MODE_FLUSH, 6'd63, 10'd1023, 10'd1023);
		// flush straight after a flush
		flush_frame();

		while (items_sent < ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			kind = (sweeps == 0) ? 1 : $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(0, 2))
					send_item(MODE_PIXEL, 6'd0, POS_W'($urandom), POS_W'($urandom));
			end else if (kind == 1 && sweeps < 3) begin
				// every label in one frame: the longest flush
				sweeps++;
				for (int k = NUM_LABELS - 1; k > 0; k--)
					send_item(MODE_PIXEL, LABEL_W'(k), pick_pos(), pick_pos());
			end else begin
				base = LABEL_W'($urandom);
				n    = $urandom_range(1, 24);
				repeat (n) begin
					lab = $urandom_range(0, 1) ? LABEL_W'(base + $urandom_range(0, 3))
					                           : LABEL_W'($urandom);
					send_item(MODE_PIXEL, lab, pick_pos(), pick_pos());
				end
			end
			flush_frame();
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		do @(posedge clk); while (boxes_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && boxes_pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_front.sv
hw/rtl/bba_back.sv
hw/rtl/label_bounding_box_accumulator_core.sv
test/bbox_checker.sv
test/testbench.sv
